/* rtl/core/assert_macros.svh */
// Assertion macros for the SHA-1 core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold at every rising clock edge outside reset.
`define SHA1_ASSERT(lbl, clk_s, rstn_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
		else $error("sha1 core: assertion failed");

// Condition must never be true at a rising clock edge outside reset.
`define SHA1_NEVER(lbl, clk_s, rstn_s, cond) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) \
		else $error("sha1 core: forbidden condition seen");

`else

`define SHA1_ASSERT(lbl, clk_s, rstn_s, prop)
`define SHA1_NEVER(lbl, clk_s, rstn_s, cond)

`endif

`endif

/* rtl/core/sha1_pkg.sv */
// Package with SHA-1 core constants, state type and helper functions.
package sha1_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned WORD_W  = 32;
	localparam int unsigned CNT_W   = 64;
	localparam int unsigned BLOCK_W = 512;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned N_WORDS = 5;
	localparam int unsigned RND_W   = 7;
	localparam int unsigned POS_W   = 6;

	localparam logic [RND_W-1:0] ROUNDS     = 7'd80;
	localparam logic [RND_W-1:0] LAST_ROUND = 7'd79;
	localparam logic [RND_W-1:0] PH1_END    = 7'd20;
	localparam logic [RND_W-1:0] PH2_END    = 7'd40;
	localparam logic [RND_W-1:0] PH3_END    = 7'd60;

	localparam logic [POS_W-1:0] LAST_POS = 6'd63;
	localparam logic [POS_W-1:0] LEN_POS  = 6'd56;
	localparam logic [POS_W-1:0] FIT_POS  = 6'd55;

	localparam logic [BYTE_W-1:0] PAD_MARK  = 8'h80;
	localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;
	localparam logic [CNT_W-1:0]  BYTE_BITS = 64'd8;

	localparam logic [IDX_W-1:0] LAST_IDX = 3'd4;

	localparam logic [WORD_W-1:0] K_PH1 = 32'h5A827999;
	localparam logic [WORD_W-1:0] K_PH2 = 32'h6ED9EBA1;
	localparam logic [WORD_W-1:0] K_PH3 = 32'h8F1BBCDC;
	localparam logic [WORD_W-1:0] K_PH4 = 32'hCA62C1D6;

	localparam logic [WORD_W-1:0] SHA1_IV [N_WORDS] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_PAD  = 5'b00010,
		ST_RND  = 5'b00100,
		ST_ADD  = 5'b01000,
		ST_DONE = 5'b10000
	} sha1_state_t;

	function automatic logic [WORD_W-1:0] rotl1(input logic [WORD_W-1:0] v);
		return {v[WORD_W-2:0], v[WORD_W-1]};
	endfunction

	function automatic logic [WORD_W-1:0] rotl5(input logic [WORD_W-1:0] v);
		return {v[WORD_W-6:0], v[WORD_W-1:WORD_W-5]};
	endfunction

	function automatic logic [WORD_W-1:0] rotl30(input logic [WORD_W-1:0] v);
		return {v[1:0], v[WORD_W-1:2]};
	endfunction

	// Word i of the schedule window, word 0 being the oldest.
	function automatic logic [WORD_W-1:0] msg_word(input logic [BLOCK_W-1:0] m,
			input int unsigned i);
		return m[BLOCK_W-1-WORD_W*i -: WORD_W];
	endfunction

endpackage

/* rtl/core/sha1_in_if.sv */
// Input channel interface: append or finish items.
interface sha1_in_if;
	import sha1_pkg::*;

	logic              valid;
	logic              ready;
	logic              action;
	logic [BYTE_W-1:0] data_byte;

	modport source (output valid, action, data_byte, input ready);
	modport sink   (input valid, action, data_byte, output ready);
endinterface

/* rtl/core/sha1_out_if.sv */
// Output channel interface: digest words.
interface sha1_out_if;
	import sha1_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] digest_word;
	logic [IDX_W-1:0]  word_index;
	logic              last;

	modport source (output valid, digest_word, word_index, last, input ready);
	modport sink   (input valid, digest_word, word_index, last, output ready);
endinterface

/* rtl/core/sha1_hash_engine.sv */
// SHA-1 hash engine top level: byte-serial input, one compression round per cycle.
// Append transfer: a byte that fills the block starts the 80 rounds and then the chaining add.
// Finish transfer: padding shifts in one pad byte at a time (up to 64, or 72 over two blocks),
// each block then runs its rounds and add, then the digest bank loads once it has drained;
// words go out 1 per cycle while out_ch.ready is high. No byte is taken outside ST_IDLE.
// arst_n low clears the sequencer, loads the initial chaining values and zeroes the count.
`include "assert_macros.svh"

module sha1_hash_engine (
	input  logic        clk,
	input  logic        arst_n,
	sha1_in_if.sink     in_ch,
	sha1_out_if.source  out_ch
);
	import sha1_pkg::*;

	// Sequencer
	sha1_state_t        state_q;
	logic [RND_W-1:0]   rnd_q;

	// Hash state
	logic [WORD_W-1:0]  chain_q [N_WORDS];
	logic [CNT_W-1:0]   bit_total_q;

	// Block buffer doubles as the 16-word schedule window.
	// Bytes shift in at the low end; after 64 bytes the first byte sits at the top.
	logic [BLOCK_W-1:0] msg_q;

	// Round working registers
	logic [WORD_W-1:0]  a_q, b_q, c_q, d_q, e_q;

	// Padding control
	logic               pad_q;    // current compression belongs to a finish
	logic               first_q;  // next pad byte is the 0x80 marker
	logic               final_q;  // this pad block carries the length
	logic [POS_W-1:0]   pos_q;    // byte position inside the pad block
	logic [CNT_W-1:0]   len_q;    // message length, shifts out msb byte first

	// Digest bank: lets the next message start while words drain
	logic [WORD_W-1:0]  out_words_q [N_WORDS];
	logic [IDX_W-1:0]   out_idx_q;
	logic               out_busy_q;

	logic               in_xfer;
	logic               out_xfer;
	logic [POS_W-1:0]   fill_pos;
	logic [BYTE_W-1:0]  pad_byte;
	logic [WORD_W-1:0]  w_cur;
	logic [WORD_W-1:0]  w_next;
	logic [WORD_W-1:0]  f_val;
	logic [WORD_W-1:0]  k_val;
	logic [WORD_W-1:0]  t_sum;

	assign in_xfer  = in_ch.valid & in_ch.ready;
	assign out_xfer = out_ch.valid & out_ch.ready;

	// Byte position follows directly from the bit count.
	assign fill_pos = bit_total_q[POS_W+2:3];

	// Pad byte: marker first, length bytes at the tail of the final block, zeros elsewhere.
	// The marker always lands below the length field in the final block.
	always_comb begin
		if (first_q) begin
			pad_byte = PAD_MARK;
		end else if (final_q && (pos_q >= LEN_POS)) begin
			pad_byte = len_q[CNT_W-1 -: BYTE_W];
		end else begin
			pad_byte = ZERO_BYTE;
		end
	end

	// Schedule: w[t] is the oldest word; w[t+16] is pushed in each round.
	// Pushing during the first 16 rounds too keeps the window aligned.
	assign w_cur  = msg_word(msg_q, 0);
	assign w_next = rotl1(msg_word(msg_q, 13) ^ msg_word(msg_q, 8) ^
		msg_word(msg_q, 2) ^ msg_word(msg_q, 0));

	// Round function and constant by round group
	always_comb begin
		if (rnd_q < PH1_END) begin
			f_val = (b_q & c_q) | (~b_q & d_q);
			k_val = K_PH1;
		end else if (rnd_q < PH2_END) begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K_PH2;
		end else if (rnd_q < PH3_END) begin
			f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k_val = K_PH3;
		end else begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K_PH4;
		end
	end

	// The one shared adder chain of the round unit
	assign t_sum = rotl5(a_q) + f_val + e_q + k_val + w_cur;

	assign in_ch.ready        = (state_q == ST_IDLE);
	assign out_ch.valid       = out_busy_q;
	assign out_ch.digest_word = out_words_q[0];
	assign out_ch.word_index  = out_idx_q;
	assign out_ch.last        = (out_idx_q == LAST_IDX);

	// Control and hash state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rnd_q       <= '0;
			bit_total_q <= '0;
			pad_q       <= 1'b0;
			first_q     <= 1'b0;
			final_q     <= 1'b0;
			pos_q       <= '0;
			out_idx_q   <= '0;
			out_busy_q  <= 1'b0;
			for (int i = 0; i < N_WORDS; i++) begin
				chain_q[i] <= SHA1_IV[i];
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (!in_ch.action) begin
							bit_total_q <= bit_total_q + BYTE_BITS;
							pad_q       <= 1'b0;
							if (fill_pos == LAST_POS) begin
								rnd_q   <= '0;
								state_q <= ST_RND;
							end
						end else begin
							// Finish: the 0x80 marker and the length fit in this block
							// only when at most 55 bytes are already there.
							pad_q   <= 1'b1;
							first_q <= 1'b1;
							final_q <= (fill_pos <= FIT_POS);
							pos_q   <= fill_pos;
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					first_q <= 1'b0;
					pos_q   <= pos_q + 1'b1;
					if (pos_q == LAST_POS) begin
						rnd_q   <= '0;
						state_q <= ST_RND;
					end
				end
				ST_RND: begin
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == LAST_ROUND) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					chain_q[0] <= chain_q[0] + a_q;
					chain_q[1] <= chain_q[1] + b_q;
					chain_q[2] <= chain_q[2] + c_q;
					chain_q[3] <= chain_q[3] + d_q;
					chain_q[4] <= chain_q[4] + e_q;
					if (!pad_q) begin
						state_q <= ST_IDLE;
					end else if (final_q) begin
						state_q <= ST_DONE;
					end else begin
						// Marker block done; a second block carries the length.
						final_q <= 1'b1;
						state_q <= ST_PAD;
					end
				end
				ST_DONE: begin
					// Wait for the bank to drain, then restart the message.
					if (!out_busy_q) begin
						out_busy_q  <= 1'b1;
						out_idx_q   <= '0;
						bit_total_q <= '0;
						pad_q       <= 1'b0;
						final_q     <= 1'b0;
						state_q     <= ST_IDLE;
						for (int i = 0; i < N_WORDS; i++) begin
							chain_q[i] <= SHA1_IV[i];
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// A word transfer can only happen while the bank is full,
			// so it never collides with the load in ST_DONE.
			if (out_xfer) begin
				out_idx_q <= out_idx_q + 1'b1;
				if (out_idx_q == LAST_IDX) begin
					out_busy_q <= 1'b0;
				end
			end
		end
	end

	// Payload registers: block buffer, round words, length, digest bank
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && in_xfer) begin
			if (!in_ch.action) begin
				msg_q <= {msg_q[BLOCK_W-BYTE_W-1:0], in_ch.data_byte};
			end else begin
				len_q <= bit_total_q;
			end
		end
		if ((state_q == ST_IDLE) && in_xfer && !in_ch.action && (fill_pos == LAST_POS)) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end
		if (state_q == ST_PAD) begin
			msg_q <= {msg_q[BLOCK_W-BYTE_W-1:0], pad_byte};
			if (final_q && !first_q && (pos_q >= LEN_POS)) begin
				len_q <= {len_q[CNT_W-BYTE_W-1:0], ZERO_BYTE};
			end
			if (pos_q == LAST_POS) begin
				a_q <= chain_q[0];
				b_q <= chain_q[1];
				c_q <= chain_q[2];
				d_q <= chain_q[3];
				e_q <= chain_q[4];
			end
		end
		if (state_q == ST_RND) begin
			msg_q <= {msg_q[BLOCK_W-WORD_W-1:0], w_next};
			e_q   <= d_q;
			d_q   <= c_q;
			c_q   <= rotl30(b_q);
			b_q   <= a_q;
			a_q   <= t_sum;
		end
		if ((state_q == ST_DONE) && !out_busy_q) begin
			for (int i = 0; i < N_WORDS; i++) begin
				out_words_q[i] <= chain_q[i];
			end
		end else if (out_xfer) begin
			for (int i = 0; i < N_WORDS - 1; i++) begin
				out_words_q[i] <= out_words_q[i+1];
			end
		end
	end

	// Checks on sequencer and digest bank
	`SHA1_ASSERT(a_rnd_range, clk, arst_n, (state_q == ST_RND) |-> (rnd_q < ROUNDS))
	`SHA1_NEVER(a_len_vs_mark, clk, arst_n, (state_q == ST_PAD) && final_q && first_q && (pos_q >= LEN_POS))
	`SHA1_ASSERT(a_last_frees_bank, clk, arst_n, (out_xfer && out_ch.last) |=> !out_busy_q)
	`SHA1_ASSERT(a_done_waits, clk, arst_n, (state_q == ST_DONE && out_busy_q) |=> (state_q == ST_DONE))

endmodule
